/* sv/sprite_frame_sequencer_assert.svh */
// Assertion macros for the sprite frame sequencer RTL.
// No dependencies; expects clk and arst_n in the including module.
`ifndef SPRITE_FRAME_SEQUENCER_ASSERT_SVH
`define SPRITE_FRAME_SEQUENCER_ASSERT_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset
`define SFS_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Expression must never be true outside reset
`define SFS_NEVER(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);
`else
`define SFS_ASSERT(label, prop, msg)
`define SFS_NEVER(label, expr, msg)
`endif
`endif

/* sv/sfs_pkg.sv */
// Package for the sprite frame sequencer: field widths, codes and the
// command/status structs between controller and datapath. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sfs_pkg;

	// Field widths
	localparam int REQ_TYPE_W  = 3;
	localparam int ELAPSED_W   = 20;
	localparam int FRAME_REQ_W = 16;
	localparam int FRAME_POS_W = 8;
	localparam int ADV_W       = 8;
	localparam int CLIP_LEN_W  = 9;
	localparam int MODE_W      = 2;
	localparam int PERIOD_W    = 20;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 20;

	// Register indexes
	localparam logic [CFG_INDEX_W-1:0] CFG_CLIP_LENGTH  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_PLAY_MODE    = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_PERIOD = 2'd2;

	// Request codes
	typedef enum logic [REQ_TYPE_W-1:0] {
		REQ_TICK      = 3'd0,
		REQ_PLAY      = 3'd1,
		REQ_STOP      = 3'd2,
		REQ_PAUSE     = 3'd3,
		REQ_RESUME    = 3'd4,
		REQ_SET_FRAME = 3'd5
	} req_code_t;

	// End-of-clip behavior
	typedef enum logic [MODE_W-1:0] {
		MODE_ONCE     = 2'd0,
		MODE_LOOP     = 2'd1,
		MODE_PINGPONG = 2'd2,
		MODE_HOLD     = 2'd3
	} play_mode_t;

	// Register reset values (period is 1e6/12 truncated, 12 frames/s)
	localparam logic [CLIP_LEN_W-1:0] CLIP_LEN_RESET = 9'd1;
	localparam play_mode_t            MODE_RESET     = MODE_LOOP;
	localparam logic [PERIOD_W-1:0]   PERIOD_RESET   = 20'd83333;

	localparam logic [ADV_W-1:0] ADV_MAX = 8'd255;

	// Controller to datapath
	typedef struct packed {
		logic capture;    // latch the request on transfer
		logic apply;      // execute a non-stepping command
		logic div_start;  // launch the divider
		logic div_mod;    // divider operands: 0 accum/period, 1 remainder/cycle
		logic latch_n;    // take quotient and remainder of the tick
		logic step;       // move one frame
		logic phase_b;    // stepping counts down the leftover steps
		logic latch_r;    // take the leftover step count
		logic load_out;   // fill the output register
	} sfs_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic tick_active;
		logic div_busy;
		logic div_done;
		logic more_n;
		logic below_pre;
		logic halt;
		logic r_zero;
	} sfs_status_t;

endpackage

`default_nettype wire

/* sv/sfs_req_if.sv */
// Request channel of the sprite frame sequencer: valid/ready plus command.
// Depends on sfs_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface sfs_req_if import sfs_pkg::*; ();
	logic                          valid;
	logic                          ready;
	logic [REQ_TYPE_W-1:0]         req_type;
	logic [ELAPSED_W-1:0]          elapsed_ticks;
	logic signed [FRAME_REQ_W-1:0] frame_request;

	modport source (
		output valid, req_type, elapsed_ticks, frame_request,
		input  ready
	);
	modport sink (
		input  valid, req_type, elapsed_ticks, frame_request,
		output ready
	);
endinterface

`default_nettype wire

/* sv/sfs_rsp_if.sv */
// Result channel of the sprite frame sequencer: valid/ready plus status.
// Depends on sfs_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface sfs_rsp_if import sfs_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [FRAME_POS_W-1:0] frame_position;
	logic                   is_playing;
	logic                   going_backward;
	logic [ADV_W-1:0]       frames_advanced;
	logic                   clip_ended;

	modport source (
		output valid, frame_position, is_playing, going_backward, frames_advanced,
		       clip_ended,
		input  ready
	);
	modport sink (
		input  valid, frame_position, is_playing, going_backward, frames_advanced,
		       clip_ended,
		output ready
	);
endinterface

`default_nettype wire

/* sv/sfs_divider.sv */
// Iterative restoring divider, one quotient bit per cycle, shared by the
// tick period division and the leftover-step modulo. Depends on the assertion macros.
`timescale 1ns / 1ps
`default_nettype none
`include "sprite_frame_sequencer_assert.svh"

module sfs_divider #(
	parameter int XW = 21
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [XW-1:0] dividend,
	input  logic [XW-1:0] divisor,
	output logic          busy,
	output logic          done,
	output logic [XW-1:0] quotient,
	output logic [XW-1:0] remainder
);

	localparam int CNTW = $clog2(XW + 1);

	logic            busy_q;
	logic            done_q;
	logic [CNTW-1:0] cnt_q;
	logic [XW-1:0]   rem_q;
	logic [XW-1:0]   quo_q;
	logic [XW-1:0]   div_q;
	logic [XW:0]     trial;
	logic [XW-1:0]   nx_rem;
	logic [XW-1:0]   nx_quo;

	// Trial subtract of the shifted partial remainder
	always_comb begin
		trial = {rem_q, quo_q[XW-1]} - {1'b0, div_q};
		if (!trial[XW]) begin
			nx_rem = trial[XW-1:0];
			nx_quo = {quo_q[XW-2:0], 1'b1};
		end else begin
			nx_rem = {rem_q[XW-2:0], quo_q[XW-1]};
			nx_quo = {quo_q[XW-2:0], 1'b0};
		end
	end

	// Iteration control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !start && busy_q && (cnt_q == CNTW'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNTW'(XW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNTW'(1);
				if (cnt_q == CNTW'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// Operand and partial result registers
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= nx_rem;
			quo_q <= nx_quo;
		end
	end

	assign busy      = busy_q;
	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

	`SFS_ASSERT(a_rem_below_div, done_q |-> (rem_q < div_q), "divider remainder not below divisor")
	`SFS_NEVER(a_busy_done, busy_q && done_q, "divider busy and done together")
	`SFS_ASSERT(a_done_at_end, $fell(busy_q) |-> done_q, "divider finished without done")

endmodule

`default_nettype wire

/* sv/sfs_ctrl.sv */
// Controller of the sprite frame sequencer: sequences decode, divisions,
// frame stepping and the output register. Depends on sfs_pkg and macros.
`timescale 1ns / 1ps
`default_nettype none
`include "sprite_frame_sequencer_assert.svh"

module sfs_ctrl import sfs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	output logic        out_valid,
	input  logic        out_ready,
	input  sfs_status_t st,
	output sfs_cmd_t    cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_DIV_N,
		S_STEP_A,
		S_DIV_R,
		S_STEP_B,
		S_FINISH
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;

	// Next state and commands
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_DECODE;
				end
			end
			S_DECODE: begin
				if (st.tick_active) begin
					cmd.div_start = 1'b1;
					state_d       = S_DIV_N;
				end else begin
					cmd.apply = 1'b1;
					state_d   = S_FINISH;
				end
			end
			S_DIV_N: begin
				if (st.div_done) begin
					cmd.latch_n = 1'b1;
					state_d     = S_STEP_A;
				end
			end
			// bounded direct stepping
			S_STEP_A: begin
				if (st.more_n && st.below_pre) begin
					cmd.step = 1'b1;
					if (st.halt) begin
						state_d = S_FINISH;
					end
				end else if (st.more_n) begin
					cmd.div_start = 1'b1;
					cmd.div_mod   = 1'b1;
					state_d       = S_DIV_R;
				end else begin
					state_d = S_FINISH;
				end
			end
			S_DIV_R: begin
				if (st.div_done) begin
					cmd.latch_r = 1'b1;
					state_d     = S_STEP_B;
				end
			end
			// leftover steps after whole cycles are folded out
			S_STEP_B: begin
				if (!st.r_zero) begin
					cmd.step    = 1'b1;
					cmd.phase_b = 1'b1;
					if (st.halt) begin
						state_d = S_FINISH;
					end
				end else begin
					state_d = S_FINISH;
				end
			end
			S_FINISH: begin
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	`SFS_ASSERT(a_accept_decode, (in_valid && in_ready) |=> (state_q == S_DECODE), "transfer not decoded")
	`SFS_NEVER(a_div_restart, cmd.div_start && st.div_busy, "divider restarted while busy")
	`SFS_ASSERT(a_valid_from_load, $rose(out_valid_q) |-> $past(cmd.load_out), "result valid without load")

endmodule

`default_nettype wire

/* sv/sfs_datapath.sv */
// Datapath of the sprite frame sequencer: configuration, sequencer state,
// frame step logic, divider and output register. Depends on sfs_pkg, sfs_divider.
`timescale 1ns / 1ps
`default_nettype none

module sfs_datapath import sfs_pkg::*; #(
	parameter int MAX_FRAMES = 256,
	parameter int TIME_BITS  = 20
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [CFG_INDEX_W-1:0]        cfg_index,
	input  logic [CFG_DATA_W-1:0]         cfg_wdata,
	input  logic [REQ_TYPE_W-1:0]         req_type,
	input  logic [ELAPSED_W-1:0]          elapsed_ticks,
	input  logic signed [FRAME_REQ_W-1:0] frame_request,
	input  sfs_cmd_t                      cmd,
	output sfs_status_t                   st,
	output logic [FRAME_POS_W-1:0]        frame_position,
	output logic                          is_playing,
	output logic                          going_backward,
	output logic [ADV_W-1:0]              frames_advanced,
	output logic                          clip_ended
);

	localparam int PW  = $clog2(MAX_FRAMES);
	localparam int LW  = $clog2(MAX_FRAMES + 1);
	localparam int EW  = LW + 1;
	localparam int CYW = LW + 1;
	localparam int NW  = TIME_BITS + 1;
	localparam int PRE = 2 * MAX_FRAMES + 4;
	localparam int SW  = $clog2(PRE + 1);
	localparam int CW  = (SW > NW) ? SW : NW;
	localparam int XA  = (NW > CYW) ? NW : CYW;
	localparam int XW  = (XA > PERIOD_W) ? XA : PERIOD_W;

	// Configuration
	logic [CLIP_LEN_W-1:0] clip_q;
	play_mode_t            mode_q;
	logic [PERIOD_W-1:0]   period_q;

	// Sequencer state
	logic [PW-1:0] pos_q;
	logic          back_q;
	logic          run_q;
	logic          started_q;
	logic [NW-1:0] time_q;

	// Request and tick work registers
	logic [REQ_TYPE_W-1:0]         req_type_q;
	logic [ELAPSED_W-1:0]          elapsed_q;
	logic signed [FRAME_REQ_W-1:0] frame_q;
	logic [NW-1:0]                 n_q;
	logic [CYW-1:0]                r_q;
	logic [SW-1:0]                 steps_q;
	logic                          big_q;
	logic                          ended_q;

	// Output register
	logic [FRAME_POS_W-1:0] out_pos_q;
	logic                   out_play_q;
	logic                   out_back_q;
	logic [ADV_W-1:0]       out_adv_q;
	logic                   out_end_q;

	logic [LW-1:0]       len;
	logic [EW-1:0]       len_e;
	logic [CYW-1:0]      cyc;
	logic [PERIOD_W-1:0] period_eff;
	logic [NW-1:0]       acc_sum;
	logic [PW-1:0]       set_top;
	logic [PW-1:0]       set_pos;
	logic [EW-1:0]       pos_e;
	logic                hit_end;
	logic [PW-1:0]       nx_pos;
	logic                nx_back;
	logic                nx_run;
	logic                step_end;
	logic                step_halt;
	logic [ADV_W-1:0]    adv;
	logic [XW-1:0]       div_a;
	logic [XW-1:0]       div_b;
	logic                div_busy;
	logic                div_done;
	logic [XW-1:0]       div_quo;
	logic [XW-1:0]       div_rem;

	// Effective clip length and wrap cycle
	always_comb begin
		if (clip_q == '0) begin
			len = LW'(1);
		end else if (32'(clip_q) > 32'(MAX_FRAMES)) begin
			len = LW'(MAX_FRAMES);
		end else begin
			len = LW'(clip_q);
		end
		len_e = EW'(len);
		case (mode_q)
			MODE_LOOP:     cyc = CYW'(len);
			MODE_PINGPONG: cyc = (len_e >= EW'(2)) ? CYW'((len_e - EW'(1)) << 1) : CYW'(1);
			default:       cyc = CYW'(1);
		endcase
	end

	assign period_eff = (period_q == '0) ? PERIOD_W'(1) : period_q;
	assign acc_sum    = time_q + NW'(elapsed_q);

	// Set-frame clamp
	always_comb begin
		set_top = started_q ? PW'(len_e - EW'(1)) : PW'(MAX_FRAMES - 1);
		if (frame_q[FRAME_REQ_W-1]) begin
			set_pos = '0;
		end else if (32'(frame_q[FRAME_REQ_W-2:0]) > 32'(set_top)) begin
			set_pos = set_top;
		end else begin
			set_pos = PW'(frame_q[FRAME_REQ_W-2:0]);
		end
	end

	// One frame step, with end-of-clip handling
	always_comb begin
		nx_pos    = pos_q;
		nx_back   = back_q;
		nx_run    = run_q;
		step_end  = 1'b0;
		step_halt = 1'b0;
		hit_end   = 1'b0;
		pos_e     = EW'(pos_q);
		if (!back_q) begin
			if (pos_e + EW'(1) >= len_e) begin
				hit_end = 1'b1;
			end else begin
				nx_pos = PW'(pos_e + EW'(1));
			end
		end else if (pos_q == '0) begin
			// bounce off the start
			nx_pos  = (len_e >= EW'(2)) ? PW'(1) : '0;
			nx_back = 1'b0;
		end else if (pos_e - EW'(1) >= len_e) begin
			hit_end = 1'b1;
		end else begin
			nx_pos = PW'(pos_e - EW'(1));
		end
		if (hit_end) begin
			case (mode_q)
				MODE_ONCE: begin
					nx_pos    = PW'(len_e - EW'(1));
					nx_run    = 1'b0;
					step_end  = 1'b1;
					step_halt = 1'b1;
				end
				MODE_LOOP: begin
					nx_pos = '0;
				end
				MODE_PINGPONG: begin
					if (len_e >= EW'(2)) begin
						nx_pos  = PW'(len_e - EW'(2));
						nx_back = 1'b1;
					end else begin
						nx_pos  = '0;
						nx_back = 1'b0;
					end
				end
				default: begin
					nx_pos    = PW'(len_e - EW'(1));
					nx_run    = 1'b0;
					step_halt = 1'b1;
				end
			endcase
		end
	end

	// Shared divider operands
	assign div_a = cmd.div_mod ? (XW'(n_q) - XW'(PRE)) : XW'(acc_sum);
	assign div_b = cmd.div_mod ? XW'(cyc) : XW'(period_eff);

	sfs_divider #(
		.XW (XW)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div_start),
		.dividend  (div_a),
		.divisor   (div_b),
		.busy      (div_busy),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	// Status to the controller
	always_comb begin
		st.tick_active = (req_type_q == REQ_TICK) && run_q && started_q;
		st.div_busy    = div_busy;
		st.div_done    = div_done;
		st.more_n      = CW'(steps_q) < CW'(n_q);
		st.below_pre   = steps_q < SW'(PRE);
		st.halt        = step_halt;
		st.r_zero      = (r_q == '0);
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clip_q   <= CLIP_LEN_RESET;
			mode_q   <= MODE_RESET;
			period_q <= PERIOD_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_CLIP_LENGTH:  clip_q   <= cfg_wdata[CLIP_LEN_W-1:0];
				CFG_PLAY_MODE:    mode_q   <= play_mode_t'(cfg_wdata[MODE_W-1:0]);
				CFG_FRAME_PERIOD: period_q <= cfg_wdata[PERIOD_W-1:0];
				default: ;
			endcase
		end
	end

	// Sequencer state updates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			back_q    <= 1'b0;
			run_q     <= 1'b0;
			started_q <= 1'b0;
			time_q    <= '0;
		end else begin
			if (cmd.apply) begin
				case (req_code_t'(req_type_q))
					REQ_PLAY: begin
						pos_q     <= '0;
						time_q    <= '0;
						back_q    <= 1'b0;
						run_q     <= 1'b1;
						started_q <= 1'b1;
					end
					REQ_STOP: begin
						run_q <= 1'b0;
						pos_q <= '0;
					end
					REQ_PAUSE:  run_q <= 1'b0;
					REQ_RESUME: run_q <= 1'b1;
					REQ_SET_FRAME: begin
						pos_q  <= set_pos;
						time_q <= '0;
					end
					default: ;
				endcase
			end
			if (cmd.latch_n) begin
				time_q <= NW'(div_rem);
			end
			if (cmd.step) begin
				pos_q  <= nx_pos;
				back_q <= nx_back;
				run_q  <= nx_run;
				if (step_halt) begin
					time_q <= '0;
				end
			end
		end
	end

	// Tick step counters and flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			steps_q <= '0;
			big_q   <= 1'b0;
			ended_q <= 1'b0;
		end else begin
			if (cmd.capture) begin
				steps_q <= '0;
				big_q   <= 1'b0;
				ended_q <= 1'b0;
			end
			if (cmd.latch_r) begin
				big_q <= 1'b1;
			end
			if (cmd.step) begin
				if (!cmd.phase_b) begin
					steps_q <= steps_q + SW'(1);
				end
				if (step_end) begin
					ended_q <= 1'b1;
				end
			end
		end
	end

	// Request capture and division results
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_type_q <= req_type;
			elapsed_q  <= elapsed_ticks;
			frame_q    <= frame_request;
		end
		if (cmd.latch_n) begin
			n_q <= NW'(div_quo);
		end
		if (cmd.latch_r) begin
			r_q <= CYW'(div_rem);
		end else if (cmd.step && cmd.phase_b) begin
			r_q <= r_q - CYW'(1);
		end
	end

	// Saturated step count of the tick
	always_comb begin
		if (big_q) begin
			adv = (CW'(n_q) > CW'(ADV_MAX)) ? ADV_MAX : ADV_W'(n_q);
		end else begin
			adv = (CW'(steps_q) > CW'(ADV_MAX)) ? ADV_MAX : ADV_W'(steps_q);
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_pos_q  <= FRAME_POS_W'(pos_q);
			out_play_q <= run_q;
			out_back_q <= back_q;
			out_adv_q  <= adv;
			out_end_q  <= ended_q;
		end
	end

	assign frame_position  = out_pos_q;
	assign is_playing      = out_play_q;
	assign going_backward  = out_back_q;
	assign frames_advanced = out_adv_q;
	assign clip_ended      = out_end_q;

endmodule

`default_nettype wire

/* sv/sprite_frame_sequencer.sv */
// Sprite frame sequencer, top level.
// Request channel req: one command per transfer (tick, play, stop, pause,
// resume, set frame); result channel rsp: one status item per command.
// Registers are written through cfg_we/cfg_index/cfg_wdata; the user must
// write them only while idle; the block does not enforce it. A command other
// than an active tick is applied in the decode state and its result loaded
// into the output register in the finish state, whereupon the controller is
// idle for the next request. An active tick (playing, clip started) divides
// the stored time plus elapsed_ticks by the frame period into frame steps
// and new time. Up to 2*MAX_FRAMES + 4 steps follow directly, one per cycle,
// from a single frame-step unit; when the step count exceeds that bound, a
// second pass of the bit-serial divider (one quotient bit per cycle) folds
// out whole loop or ping-pong cycles and the leftover steps follow. Stepping
// ends early when a step halts the clip. The divider is XW bits wide, with
// XW = max(TIME_BITS + 1, 20, clog2(MAX_FRAMES + 1) + 1) (21 by default).
// Reset clears the sequencer to frame 0, stopped, forward, no clip played,
// and loads the register defaults. A stalled receiver holds the result in
// the output register; one further request is processed meanwhile and its
// result waits until the register frees.
// Depends on sfs_pkg, sfs_req_if, sfs_rsp_if, sfs_ctrl, sfs_datapath.
`timescale 1ns / 1ps
`default_nettype none

module sprite_frame_sequencer import sfs_pkg::*; #(
	parameter int MAX_FRAMES = 256,
	parameter int TIME_BITS  = 20
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_wdata,
	sfs_req_if.sink                req,
	sfs_rsp_if.source              rsp
);

	sfs_cmd_t    cmd;
	sfs_status_t st;

	// Sequencing control
	sfs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.st        (st),
		.cmd       (cmd)
	);

	// State, arithmetic and result register
	sfs_datapath #(
		.MAX_FRAMES (MAX_FRAMES),
		.TIME_BITS  (TIME_BITS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_wdata       (cfg_wdata),
		.req_type        (req.req_type),
		.elapsed_ticks   (req.elapsed_ticks),
		.frame_request   (req.frame_request),
		.cmd             (cmd),
		.st              (st),
		.frame_position  (rsp.frame_position),
		.is_playing      (rsp.is_playing),
		.going_backward  (rsp.going_backward),
		.frames_advanced (rsp.frames_advanced),
		.clip_ended      (rsp.clip_ended)
	);

endmodule

`default_nettype wire
